/* rtl/sliding_window_sender_tracker_assert.svh */
// ----------------------------------------------------------------------------
// Sliding window sender tracker: assertion macros
// Clocked assertion shorthands shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_TRACKER_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/swst_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window sender tracker: package
// Field widths, command and result codes, configuration indexes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swst_pkg;

    localparam int SEQ_W          = 32;
    localparam int OFF_W          = 32;
    localparam int CMD_W          = 2;
    localparam int KIND_W         = 4;
    localparam int WIN_W          = 4;
    localparam int RETRY_W        = 3;
    localparam int SECS_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int RES_W          = 4;

    localparam int DEF_MAX_WINDOW  = 8;
    localparam int DEF_LENGTH_BITS = 11;

    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 4'd5;
    localparam logic [RETRY_W-1:0] RETRIES_RESET = 3'd5;
    localparam logic [SECS_W-1:0]  GIVE_UP_RESET = 8'd30;
    localparam logic [RETRY_W-1:0] RETRY_SAT     = 3'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEGMENT  = 2'd0,
        CMD_ACK      = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRANSMIT    = 4'd0,
        KIND_WINDOW_FULL = 4'd1,
        KIND_ACK_OK      = 4'd2,
        KIND_ACK_IGNORED = 4'd3,
        KIND_RETRANSMIT  = 4'd4,
        KIND_RETRY_LIMIT = 4'd5,
        KIND_SERVER_LOST = 4'd6,
        KIND_NONE_PEND   = 4'd7,
        KIND_HALTED      = 4'd8
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_MAX_RETRIES = 2'd1,
        CFG_GIVE_UP     = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

/* rtl/swst_ram.sv */
// ----------------------------------------------------------------------------
// Sliding window sender tracker: generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sliding_window_sender_tracker.sv */
// ----------------------------------------------------------------------------
// Sliding window sender tracker
// Transmit-side window bookkeeping for a selective-repeat transfer.
// ----------------------------------------------------------------------------
// A new segment, a refused or halted command, an ignored acknowledgement or a lost
// server is answered in the cycle after start. An accepted acknowledgement slides
// the base over each freed slot in ST_SLIDE. A timeout tick scans the window in
// ST_SCAN, with a read-modify-write of the slot RAM in ST_SCAN_WB per pending slot.
// One command at a time; busy falls as the final result is registered and results
// cannot be stalled. Asynchronous reset clears the window, marks and halt flag.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_sender_tracker #(
    parameter int MAX_WINDOW  = swst_pkg::DEF_MAX_WINDOW,
    parameter int LENGTH_BITS = swst_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [swst_pkg::CMD_W-1:0]       command,
    input  wire logic [swst_pkg::OFF_W-1:0]       segment_offset,
    input  wire logic [LENGTH_BITS-1:0]           segment_length,
    input  wire logic [swst_pkg::SEQ_W-1:0]       ack_number,
    input  wire logic [swst_pkg::SECS_W-1:0]      idle_seconds,
    input  wire logic                             cfg_write,
    input  wire logic [swst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  result_valid,
    output logic [swst_pkg::KIND_W-1:0]           kind,
    output logic [swst_pkg::SEQ_W-1:0]            seq,
    output logic [swst_pkg::OFF_W-1:0]            offset,
    output logic [LENGTH_BITS-1:0]                length,
    output logic [swst_pkg::SEQ_W-1:0]            window_base,
    output logic [swst_pkg::SEQ_W-1:0]            next_number,
    output logic                                  last
);

    import swst_pkg::*;

    `include "sliding_window_sender_tracker_assert.svh"

    localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_CAP = (MAX_WINDOW < MAX_RESULTS) ? MAX_WINDOW : MAX_RESULTS;
    localparam int RAM_W   = OFF_W + LENGTH_BITS + RETRY_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SLIDE   = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_SCAN_WB = 5'b01000,
        ST_FLUSH   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [WIN_W-1:0]      window_size_reg, window_size_next;
    logic [RETRY_W-1:0]    max_retries_reg, max_retries_next;
    logic [SECS_W-1:0]     give_up_reg, give_up_next;
    logic [SEQ_W-1:0]      base_reg, base_next;
    logic [SEQ_W-1:0]      assign_reg, assign_next;
    logic [SLOT_W-1:0]     base_slot_reg, base_slot_next;
    logic [MAX_WINDOW-1:0] pending_reg, pending_next;
    logic                  halted_reg, halted_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  result_valid_reg;

    kind_t                 hold_kind_reg, hold_kind_next;
    logic [SEQ_W-1:0]      hold_seq_reg, hold_seq_next;
    logic [OFF_W-1:0]      hold_off_reg, hold_off_next;
    logic [LENGTH_BITS-1:0] hold_len_reg, hold_len_next;
    logic [SEQ_W-1:0]      ack_reg, ack_next;
    logic [RES_W-1:0]      d_reg, d_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;

    kind_t                 kind_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [OFF_W-1:0]      offset_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    logic                  last_reg;

    logic                  emit_valid;
    kind_t                 emit_kind;
    logic [SEQ_W-1:0]      emit_seq;
    logic [OFF_W-1:0]      emit_off;
    logic [LENGTH_BITS-1:0] emit_len;
    logic                  emit_last;

    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_wr_addr;
    logic [RAM_W-1:0]      ram_wr_data;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    logic [RAM_W-1:0]      ram_rd_data;

    logic [SEQ_W-1:0]      occ_full;
    logic [RES_W-1:0]      occ_n;
    logic [WIN_W-1:0]      eff_window;
    logic [SEQ_W-1:0]      ack_dist;
    logic [SEQ_W-1:0]      d_wide;
    logic [SLOT_W-1:0]     scan_slot;
    logic [OFF_W-1:0]      rd_off;
    logic [LENGTH_BITS-1:0] rd_len;
    logic [RETRY_W-1:0]    rd_retry;
    logic [RETRY_W-1:0]    new_retry;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] bs,
                                                  input logic [SEQ_W-1:0] span);
        logic [SLOT_W:0] sum;
        sum = {1'b0, bs} + {1'b0, span[SLOT_W-1:0]};
        if (sum >= (SLOT_W + 1)'(MAX_WINDOW))
        begin
            sum = sum - (SLOT_W + 1)'(MAX_WINDOW);
        end
        return sum[SLOT_W-1:0];
    endfunction

    swst_ram #(
        .WIDTH  (RAM_W),
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign occ_full  = assign_reg - base_reg;
    assign occ_n     = occ_full[RES_W-1:0];
    assign ack_dist  = ack_number - base_reg;
    assign d_wide    = {{(SEQ_W - RES_W){1'b0}}, d_reg};
    assign scan_slot = slot_of(base_slot_reg, d_wide);
    assign rd_off    = ram_rd_data[RAM_W-1 -: OFF_W];
    assign rd_len    = ram_rd_data[RETRY_W +: LENGTH_BITS];
    assign rd_retry  = ram_rd_data[RETRY_W-1:0];
    assign new_retry = (rd_retry == RETRY_SAT) ? RETRY_SAT : rd_retry + RETRY_W'(1);

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_window = WIN_W'(1);
        end
        else if (window_size_reg > WIN_W'(WIN_CAP))
        begin
            eff_window = WIN_W'(WIN_CAP);
        end
        else
        begin
            eff_window = window_size_reg;
        end
    end

    always_comb
    begin
        window_size_next = window_size_reg;
        max_retries_next = max_retries_reg;
        give_up_next     = give_up_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE: window_size_next = cfg_data[WIN_W-1:0];
                CFG_MAX_RETRIES: max_retries_next = cfg_data[RETRY_W-1:0];
                CFG_GIVE_UP:     give_up_next     = cfg_data[SECS_W-1:0];
                default:         window_size_next = window_size_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        assign_next     = assign_reg;
        base_slot_next  = base_slot_reg;
        pending_next    = pending_reg;
        halted_next     = halted_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_seq_next   = hold_seq_reg;
        hold_off_next   = hold_off_reg;
        hold_len_next   = hold_len_reg;
        ack_next        = ack_reg;
        d_next          = d_reg;
        rd_slot_next    = rd_slot_reg;

        emit_valid = 1'b0;
        emit_kind  = KIND_HALTED;
        emit_seq   = '0;
        emit_off   = '0;
        emit_len   = '0;
        emit_last  = 1'b0;

        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_of(base_slot_reg, occ_full);
        ram_wr_data = {segment_offset, segment_length, RETRY_W'(0)};
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    emit_valid = 1'b1;
                    emit_last  = 1'b1;
                    if (halted_reg || command == CMD_RESERVED)
                    begin
                        emit_kind = KIND_HALTED;
                    end
                    else if (command == CMD_SEGMENT)
                    begin
                        if (occ_full < {{(SEQ_W - WIN_W){1'b0}}, eff_window})
                        begin
                            ram_wr_en = 1'b1;
                            pending_next[ram_wr_addr] = 1'b1;
                            assign_next = assign_reg + SEQ_W'(1);
                            emit_kind   = KIND_TRANSMIT;
                            emit_seq    = assign_reg;
                            emit_off    = segment_offset;
                            emit_len    = segment_length;
                        end
                        else
                        begin
                            emit_kind = KIND_WINDOW_FULL;
                        end
                    end
                    else if (command == CMD_ACK)
                    begin
                        if (ack_dist < occ_full && ack_dist < SEQ_W'(MAX_WINDOW)
                            && pending_reg[slot_of(base_slot_reg, ack_dist)])
                        begin
                            pending_next[slot_of(base_slot_reg, ack_dist)] = 1'b0;
                            ack_next   = ack_number;
                            emit_valid = 1'b0;
                            state_next = ST_SLIDE;
                        end
                        else
                        begin
                            emit_kind = KIND_ACK_IGNORED;
                            emit_seq  = ack_number;
                        end
                    end
                    else if (idle_seconds >= give_up_reg)
                    begin
                        halted_next = 1'b1;
                        emit_kind   = KIND_SERVER_LOST;
                    end
                    else
                    begin
                        emit_valid      = 1'b0;
                        d_next          = '0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SLIDE:
            begin
                if (base_reg != assign_reg && !pending_reg[base_slot_reg])
                begin
                    base_next = base_reg + SEQ_W'(1);
                    if (base_slot_reg == SLOT_W'(MAX_WINDOW - 1))
                    begin
                        base_slot_next = '0;
                    end
                    else
                    begin
                        base_slot_next = base_slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    emit_valid = 1'b1;
                    emit_last  = 1'b1;
                    emit_kind  = KIND_ACK_OK;
                    emit_seq   = ack_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (d_reg == occ_n)
                begin
                    emit_valid = 1'b1;
                    emit_last  = 1'b1;
                    if (hold_valid_reg)
                    begin
                        emit_kind = hold_kind_reg;
                        emit_seq  = hold_seq_reg;
                        emit_off  = hold_off_reg;
                        emit_len  = hold_len_reg;
                    end
                    else
                    begin
                        emit_kind = KIND_NONE_PEND;
                    end
                    state_next = ST_IDLE;
                end
                else if (!pending_reg[scan_slot])
                begin
                    d_next = d_reg + RES_W'(1);
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    rd_slot_next = scan_slot;
                    state_next   = ST_SCAN_WB;
                end
            end

            ST_SCAN_WB:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = rd_slot_reg;
                ram_wr_data = {rd_off, rd_len, new_retry};
                if (hold_valid_reg)
                begin
                    emit_valid = 1'b1;
                    emit_kind  = hold_kind_reg;
                    emit_seq   = hold_seq_reg;
                    emit_off   = hold_off_reg;
                    emit_len   = hold_len_reg;
                end
                hold_valid_next = 1'b1;
                hold_seq_next   = base_reg + d_wide;
                hold_off_next   = rd_off;
                hold_len_next   = rd_len;
                if (new_retry >= max_retries_reg)
                begin
                    hold_kind_next = KIND_RETRY_LIMIT;
                    halted_next    = 1'b1;
                    state_next     = ST_FLUSH;
                end
                else
                begin
                    hold_kind_next = KIND_RETRANSMIT;
                    d_next         = d_reg + RES_W'(1);
                    state_next     = ST_SCAN;
                end
            end

            ST_FLUSH:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                emit_kind  = hold_kind_reg;
                emit_seq   = hold_seq_reg;
                emit_off   = hold_off_reg;
                emit_len   = hold_len_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_size_reg  <= WINDOW_RESET;
            max_retries_reg  <= RETRIES_RESET;
            give_up_reg      <= GIVE_UP_RESET;
            base_reg         <= '0;
            assign_reg       <= '0;
            base_slot_reg    <= '0;
            pending_reg      <= '0;
            halted_reg       <= 1'b0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_size_reg  <= window_size_next;
            max_retries_reg  <= max_retries_next;
            give_up_reg      <= give_up_next;
            base_reg         <= base_next;
            assign_reg       <= assign_next;
            base_slot_reg    <= base_slot_next;
            pending_reg      <= pending_next;
            halted_reg       <= halted_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_kind_reg <= hold_kind_next;
        hold_seq_reg  <= hold_seq_next;
        hold_off_reg  <= hold_off_next;
        hold_len_reg  <= hold_len_next;
        ack_reg       <= ack_next;
        d_reg         <= d_next;
        rd_slot_reg   <= rd_slot_next;
        kind_reg      <= emit_kind;
        seq_reg       <= emit_seq;
        offset_reg    <= emit_off;
        length_reg    <= emit_len;
        last_reg      <= emit_last;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign seq          = seq_reg;
    assign offset       = offset_reg;
    assign length       = length_reg;
    assign window_base  = base_reg;
    assign next_number  = assign_reg;
    assign last         = last_reg;

    `SWST_ASSERT_SAME(a_occ_bounded, 1'b1, occ_full <= SEQ_W'(WIN_CAP),
        "occupancy exceeds the window capacity")
    `SWST_ASSERT_SAME(a_pending_in_window, 1'b1,
        $countones(pending_reg) <= int'(occ_n),
        "more pending marks than segments in flight")
    `SWST_ASSERT_SAME(a_busy_ends_with_last, $fell(busy), result_valid && last,
        "command finished without a final result")
    `SWST_ASSERT_NEXT(a_halted_answers, start && !busy && halted_reg,
        result_valid && last && kind == KIND_HALTED,
        "halted block answered a transaction with the wrong result")

endmodule

`default_nettype wire
